// ----- rtl/core/chbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbm_pkg
// Shared types, mode codes and helpers for the channel blend unit.
// ----------------------------------------------------------------------------
package chbm_pkg;

    localparam int NUM_STAGES = 9;
    localparam int NUM_CHAN   = 3;

    typedef enum logic [4:0] {
        MODE_NORMAL     = 5'd0,
        MODE_LIGHTEN    = 5'd1,
        MODE_DARKEN     = 5'd2,
        MODE_MULTIPLY   = 5'd3,
        MODE_AVERAGE    = 5'd4,
        MODE_ADD        = 5'd5,
        MODE_SUBTRACT   = 5'd6,
        MODE_DIFFERENCE = 5'd7,
        MODE_NEGATION   = 5'd8,
        MODE_SCREEN     = 5'd9,
        MODE_EXCLUSION  = 5'd10,
        MODE_OVERLAY    = 5'd11,
        MODE_SOFT_LIGHT = 5'd12,
        MODE_HARD_LIGHT = 5'd13,
        MODE_DODGE      = 5'd14,
        MODE_BURN       = 5'd15,
        MODE_LIN_DODGE  = 5'd16,
        MODE_LIN_BURN   = 5'd17,
        MODE_LIN_LIGHT  = 5'd18,
        MODE_VIVID      = 5'd19,
        MODE_PIN_LIGHT  = 5'd20,
        MODE_HARD_MIX   = 5'd21,
        MODE_REFLECT    = 5'd22,
        MODE_GLOW       = 5'd23,
        MODE_PHOENIX    = 5'd24,
        MODE_DIVIDE     = 5'd25
    } mode_t;

    typedef enum logic {
        REG_BLEND_MODE = 1'b0,
        REG_MASK_ALPHA = 1'b1
    } reg_idx_t;

    localparam logic [8:0] FULL_WEIGHT = 9'd256;

    // per-channel pipeline payload; later stages fill in more fields
    typedef struct packed {
        logic [7:0]  s;
        logic [7:0]  m;
        logic [7:0]  u;      // operand in the source role (swapped modes exchange)
        logic [7:0]  v;      // operand in the mask role
        logic [7:0]  mm;     // doubled mask for the composite modes
        logic [7:0]  pa;
        logic [7:0]  pb;
        logic [15:0] prod;
        logic [16:0] x;      // dividend for the /255 path
        logic [9:0]  t;      // x / 255
        logic [15:0] num;
        logic [7:0]  den;
        logic [8:0]  rem;
        logic [7:0]  quo;
        logic        sat;
        logic        burn;
        logic [7:0]  keep;
        logic [7:0]  other;
        logic [7:0]  res;
    } chan_t;

    function automatic logic [7:0] add_clip(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? 8'd255 : sum[7:0];
    endfunction

    function automatic logic [7:0] sub_clip(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum < 9'd255) ? 8'd0 : 8'(sum - 9'd255);
    endfunction

    // two restoring division steps; returns {remainder, quotient bits}
    function automatic logic [10:0] div2(input logic [8:0] rem, input logic [7:0] den,
                                         input logic [1:0] bits);
        logic [8:0] r;
        logic [1:0] q;
        r = {rem[7:0], bits[1]};
        q = 2'b00;
        if (r >= {1'b0, den})
        begin
            r = r - {1'b0, den};
            q[1] = 1'b1;
        end
        r = {r[7:0], bits[0]};
        if (r >= {1'b0, den})
        begin
            r = r - {1'b0, den};
            q[0] = 1'b1;
        end
        return {r, q};
    endfunction

endpackage

// ----- rtl/core/channel_blend_mode_unit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_blend_mode_unit_core
// Per-channel layer blend of a source pixel with a mask pixel.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per beat (source alpha/RGB, mask RGB); m_axis
//   returns one blended pixel per beat, source alpha passed through.
//   The cfg channel writes blend_mode (index 0) and mask_alpha (index 1);
//   cfg_ready is always high. Write it only while no pixel is in flight.
//   Throughput is one pixel per clock while the output is not stalled. The
//   nine stages are: operand select, 8x8 product, divide setup and /255
//   estimate, four radix-4 divider stages, blend select, alpha mix. One
//   divider and two multipliers (product, alpha mix) per channel.
//   Reset clears the valid bits and the registers (mode normal, alpha 0).
//   When m_axis_tready is low with a result waiting, the stages back to the
//   nearest bubble hold; s_axis_tready drops only when every stage is full,
//   and no beat is lost or repeated. Bubbles let input be taken while the output waits.
// ----------------------------------------------------------------------------
module channel_blend_mode_unit_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // src_alpha, src_red, src_green, src_blue, mask_red, mask_green, mask_blue
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_alpha, out_red, out_green, out_blue
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int NS = chbm_pkg::NUM_STAGES;
    localparam int NC = chbm_pkg::NUM_CHAN;

    logic [4:0]           mode_reg;
    logic [8:0]           alpha_reg;
    logic [8:0]           a_sat;
    logic [NS-1:0]        vld_reg;
    logic [NS-1:0]        vld_next;
    logic [7:0]           pa_reg   [NS];
    logic [7:0]           pa_next  [NS];
    chbm_pkg::chan_t      pipe_reg [NS][NC];
    chbm_pkg::chan_t      pipe_next[NS][NC];
    logic                 adv;

    assign cfg_ready     = 1'b1;
    assign a_sat         = (alpha_reg > chbm_pkg::FULL_WEIGHT) ? chbm_pkg::FULL_WEIGHT
                                                               : alpha_reg;
    // gaps in the pipe absorb input while the output is held
    assign adv           = !(&vld_reg) || m_axis_tready || !vld_reg[NS-1];
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = {pipe_reg[NS-1][2].res, pipe_reg[NS-1][1].res,
                            pipe_reg[NS-1][0].res, pa_reg[NS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 5'd0;
            alpha_reg <= 9'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                chbm_pkg::REG_BLEND_MODE: mode_reg  <= cfg_data[4:0];
                chbm_pkg::REG_MASK_ALPHA: alpha_reg <= cfg_data;
                default:                  mode_reg  <= mode_reg;
            endcase
        end
    end

    // stall model: stage i moves when it is empty or the next stage moves
    logic [NS:0] mv;
    always_comb
    begin
        mv[NS] = !vld_reg[NS-1] || m_axis_tready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            mv[i] = mv[i+1] || !vld_reg[i];
        end
    end

    always_comb
    begin
        logic [7:0]  s, m, u, v, k;
        logic        sw, mhi;
        logic [17:0] est, r;
        logic [10:0] dr;
        logic [7:0]  b, dq, mx, mn;
        logic [8:0]  sm;
        logic signed [8:0]  d;
        logic signed [18:0] mp;
        logic signed [19:0] mixv;
        chbm_pkg::chan_t    n;

        vld_next[0] = s_axis_tvalid;
        pa_next[0]  = s_axis_tdata[7:0];
        for (int i = 1; i < NS; i++)
        begin
            vld_next[i] = vld_reg[i-1];
            pa_next[i]  = pa_reg[i-1];
        end

        for (int c = 0; c < NC; c++)
        begin
            // stage 0: operand select
            s   = s_axis_tdata[8*(c+1) +: 8];
            m   = s_axis_tdata[8*(c+4) +: 8];
            sw  = (mode_reg == chbm_pkg::MODE_HARD_LIGHT) || (mode_reg == chbm_pkg::MODE_GLOW);
            u   = sw ? m : s;
            v   = sw ? s : m;
            k   = {1'b0, v[7:1]} + 8'd64;
            n       = '0;
            n.s     = s;
            n.m     = m;
            n.u     = u;
            n.v     = v;
            n.mm    = {m[6:0], 1'b0};
            case (mode_reg) inside
                chbm_pkg::MODE_MULTIPLY, chbm_pkg::MODE_EXCLUSION:
                begin
                    n.pa = u;
                    n.pb = v;
                end
                chbm_pkg::MODE_OVERLAY, chbm_pkg::MODE_HARD_LIGHT:
                begin
                    n.pa = v[7] ? 8'd255 - u : u;
                    n.pb = v[7] ? 8'd255 - v : v;
                end
                chbm_pkg::MODE_SCREEN:
                begin
                    n.pa = 8'd255 - u;
                    n.pb = 8'd255 - v;
                end
                chbm_pkg::MODE_SOFT_LIGHT:
                begin
                    n.pa = u[7] ? 8'd255 - k : k;
                    n.pb = u[7] ? 8'd255 - u : u;
                end
                chbm_pkg::MODE_REFLECT, chbm_pkg::MODE_GLOW:
                begin
                    n.pa = u;
                    n.pb = u;
                end
                default:
                begin
                    n.pa = 8'd0;
                    n.pb = 8'd0;
                end
            endcase
            pipe_next[0][c] = n;

            // stage 1: product
            n      = pipe_reg[0][c];
            n.prod = n.pa * n.pb;
            pipe_next[1][c] = n;

            // stage 2: /255 estimate and divider setup
            n   = pipe_reg[1][c];
            mhi = n.m[7];
            if (mode_reg == chbm_pkg::MODE_MULTIPLY)
                n.x = {1'b0, n.prod};
            else if ((mode_reg == chbm_pkg::MODE_SOFT_LIGHT) && n.u[7])
                n.x = {n.prod, 1'b0} + 17'd254;
            else
                n.x = {n.prod, 1'b0};
            est  = {1'b0, n.x} + {9'd0, n.x[16:8]} + {17'd0, n.x[16]};
            n.t  = est[17:8];
            n.burn = 1'b0;
            case (mode_reg) inside
                chbm_pkg::MODE_DODGE:
                begin
                    n.num = {n.u, 8'd0};
                    n.den = 8'd255 - n.v;
                end
                chbm_pkg::MODE_BURN:
                begin
                    n.num  = {8'd255 - n.u, 8'd0};
                    n.den  = n.v;
                    n.burn = 1'b1;
                end
                chbm_pkg::MODE_VIVID, chbm_pkg::MODE_HARD_MIX:
                begin
                    n.num  = mhi ? {n.s, 8'd0} : {8'd255 - n.s, 8'd0};
                    n.den  = mhi ? 8'd255 - n.mm : n.mm;
                    n.burn = !mhi;
                end
                chbm_pkg::MODE_REFLECT, chbm_pkg::MODE_GLOW:
                begin
                    n.num = n.prod;
                    n.den = 8'd255 - n.v;
                end
                chbm_pkg::MODE_DIVIDE:
                begin
                    n.num = {n.u, 8'd0} - {8'd0, n.u};
                    n.den = n.v;
                end
                default:
                begin
                    n.num = 16'd0;
                    n.den = 8'd1;
                end
            endcase
            // quotient above 255 (or zero divisor) saturates
            n.sat = (n.num[15:8] >= n.den);
            n.rem = {1'b0, n.num[15:8]};
            n.quo = 8'd0;
            pipe_next[2][c] = n;

            // stage 3: /255 correction, quotient bits 7:6
            n  = pipe_reg[2][c];
            r  = {1'b0, n.x} - ({n.t, 8'd0} - {8'd0, n.t});
            if (r >= 18'd510)
                n.t = n.t + 10'd2;
            else if (r >= 18'd255)
                n.t = n.t + 10'd1;
            dr    = chbm_pkg::div2(n.rem, n.den, n.num[7:6]);
            n.rem = dr[10:2];
            n.quo = {n.quo[5:0], dr[1:0]};
            pipe_next[3][c] = n;

            // stages 4..6: remaining quotient bits
            n     = pipe_reg[3][c];
            dr    = chbm_pkg::div2(n.rem, n.den, n.num[5:4]);
            n.rem = dr[10:2];
            n.quo = {n.quo[5:0], dr[1:0]};
            pipe_next[4][c] = n;

            n     = pipe_reg[4][c];
            dr    = chbm_pkg::div2(n.rem, n.den, n.num[3:2]);
            n.rem = dr[10:2];
            n.quo = {n.quo[5:0], dr[1:0]};
            pipe_next[5][c] = n;

            n     = pipe_reg[5][c];
            dr    = chbm_pkg::div2(n.rem, n.den, n.num[1:0]);
            n.rem = dr[10:2];
            n.quo = {n.quo[5:0], dr[1:0]};
            pipe_next[6][c] = n;

            // stage 7: blend value and mix operands
            n   = pipe_reg[6][c];
            mhi = n.m[7];
            if (n.burn)
                dq = n.sat ? 8'd0 : 8'd255 - n.quo;
            else
                dq = n.sat ? 8'd255 : n.quo;
            mx = (n.s > n.m) ? n.s : n.m;
            mn = (n.s > n.m) ? n.m : n.s;
            sm = {1'b0, n.s} + {1'b0, n.m};
            case (mode_reg) inside
                chbm_pkg::MODE_LIGHTEN:    b = mx;
                chbm_pkg::MODE_DARKEN:     b = mn;
                chbm_pkg::MODE_MULTIPLY:   b = n.t[7:0];
                chbm_pkg::MODE_AVERAGE:    b = sm[8:1];
                chbm_pkg::MODE_ADD, chbm_pkg::MODE_LIN_DODGE:
                    b = chbm_pkg::add_clip(n.s, n.m);
                chbm_pkg::MODE_SUBTRACT, chbm_pkg::MODE_LIN_BURN:
                    b = chbm_pkg::sub_clip(n.s, n.m);
                chbm_pkg::MODE_DIFFERENCE: b = mx - mn;
                chbm_pkg::MODE_NEGATION:
                    b = (sm > 9'd255) ? 8'(9'd510 - sm) : sm[7:0];
                chbm_pkg::MODE_SCREEN:     b = 8'd255 - n.prod[15:8];
                chbm_pkg::MODE_EXCLUSION:  b = 8'(sm - {1'b0, n.t[7:0]});
                chbm_pkg::MODE_OVERLAY, chbm_pkg::MODE_HARD_LIGHT:
                    b = n.v[7] ? 8'd255 - n.t[7:0] : n.t[7:0];
                chbm_pkg::MODE_SOFT_LIGHT:
                    b = n.u[7] ? 8'd255 - n.t[7:0] : n.t[7:0];
                chbm_pkg::MODE_LIN_LIGHT:
                    b = mhi ? chbm_pkg::add_clip(n.s, n.mm) : chbm_pkg::sub_clip(n.s, n.mm);
                chbm_pkg::MODE_PIN_LIGHT:
                    b = mhi ? ((n.s > n.mm) ? n.s : n.mm) : ((n.s < n.mm) ? n.s : n.mm);
                chbm_pkg::MODE_PHOENIX:    b = 8'(9'd255 + {1'b0, mn} - {1'b0, mx});
                chbm_pkg::MODE_DODGE, chbm_pkg::MODE_BURN, chbm_pkg::MODE_VIVID,
                chbm_pkg::MODE_HARD_MIX, chbm_pkg::MODE_REFLECT, chbm_pkg::MODE_GLOW,
                chbm_pkg::MODE_DIVIDE:     b = dq;
                default:                   b = n.s;
            endcase
            case (mode_reg) inside
                chbm_pkg::MODE_NORMAL:
                begin
                    n.keep  = n.s;
                    n.other = (n.m == 8'd0) ? n.s : n.m;
                end
                chbm_pkg::MODE_HARD_LIGHT, chbm_pkg::MODE_GLOW:
                begin
                    n.keep  = n.s;
                    n.other = b;
                end
                [chbm_pkg::MODE_LIN_LIGHT:chbm_pkg::MODE_HARD_MIX]:
                begin
                    n.keep  = n.mm;
                    n.other = b;
                end
                [chbm_pkg::MODE_LIGHTEN:chbm_pkg::MODE_DIVIDE]:
                begin
                    n.keep  = n.m;
                    n.other = b;
                end
                default:
                begin
                    // unused codes bypass the source channel
                    n.keep  = n.s;
                    n.other = n.s;
                end
            endcase
            pipe_next[7][c] = n;

            // stage 8: other + a*(keep-other)/256
            n    = pipe_reg[7][c];
            d    = $signed({1'b0, n.keep}) - $signed({1'b0, n.other});
            mp   = $signed({1'b0, a_sat}) * d;
            mixv = $signed({12'd0, n.other}) + 20'(mp >>> 8);
            if (mode_reg == chbm_pkg::MODE_HARD_MIX)
                n.res = mixv[7] ? 8'd255 : 8'd0;
            else
                n.res = mixv[7:0];
            pipe_next[8][c] = n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (mv[i])
                    vld_reg[i] <= (i == 0) ? s_axis_tvalid : vld_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (mv[i])
            begin
                pa_reg[i] <= pa_next[i];
                for (int c = 0; c < NC; c++)
                begin
                    pipe_reg[i][c] <= pipe_next[i][c];
                end
            end
        end
    end

endmodule

// ----- sim/tb_channel_blend_mode_unit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_blend_mode_unit_core
// Drives random and corner pixels through every blend mode with fixed and random alpha
// settings and checks each output pixel against an in-bench channel blend predictor.
// ----------------------------------------------------------------------------
module tb_channel_blend_mode_unit_core;

    class blend_scoreboard;
        logic [31:0] pending[$];
        int          errors;
        logic [4:0]  mode;
        logic [8:0]  alpha;

        function new();
            errors = 0;
            mode   = chbm_pkg::MODE_NORMAL;
            alpha  = 9'd0;
        endfunction

        function int mixw(int a, int keep, int other);
            int v;
            v = (a * keep + (256 - a) * other) >> 8;
            return v > 255 ? 255 : v;
        endfunction

        function int ovl(int s, int m);
            if (m < 128) return (2 * s * m) / 255;
            return 255 - (2 * (255 - s) * (255 - m)) / 255;
        endfunction

        function int dodge(int s, int m);
            int q;
            if (m >= 255) return 255;
            q = (s * 256) / (255 - m);
            return q > 255 ? 255 : q;
        endfunction

        function int burn(int s, int m);
            int q;
            if (m == 0) return 0;
            q = ((255 - s) * 256) / m;
            return q > 255 ? 0 : 255 - q;
        endfunction

        function int refl(int s, int m);
            int q;
            if (m >= 255) return 255;
            q = (s * s) / (255 - m);
            return q > 255 ? 255 : q;
        endfunction

        function int addc(int s, int m);
            return s + m > 255 ? 255 : s + m;
        endfunction

        function int subc(int s, int m);
            return s + m < 255 ? 0 : s + m - 255;
        endfunction

        function int vivid(int s, int m, int a);
            int mm;
            mm = m < 128 ? 2 * m : 2 * (m - 128);
            return mixw(a, mm, m < 128 ? burn(s, mm) : dodge(s, mm));
        endfunction

        function int blend_channel(int s, int m, int a);
            int b;
            int mm;
            int k;
            mm = m < 128 ? 2 * m : 2 * (m - 128);
            case (mode)
                chbm_pkg::MODE_NORMAL:     return m == 0 ? s : mixw(a, s, m);
                chbm_pkg::MODE_LIGHTEN:    b = s > m ? s : m;
                chbm_pkg::MODE_DARKEN:     b = s < m ? s : m;
                chbm_pkg::MODE_MULTIPLY:   b = (s * m) / 255;
                chbm_pkg::MODE_AVERAGE:    b = (s + m) >> 1;
                chbm_pkg::MODE_ADD, chbm_pkg::MODE_LIN_DODGE:      b = addc(s, m);
                chbm_pkg::MODE_SUBTRACT, chbm_pkg::MODE_LIN_BURN:  b = subc(s, m);
                chbm_pkg::MODE_DIFFERENCE: b = s > m ? s - m : m - s;
                chbm_pkg::MODE_NEGATION:   b = s + m > 255 ? 510 - s - m : s + m;
                chbm_pkg::MODE_SCREEN:     b = 255 - (((255 - s) * (255 - m)) >> 8);
                chbm_pkg::MODE_EXCLUSION:  b = s + m - (2 * s * m) / 255;
                chbm_pkg::MODE_OVERLAY:    b = ovl(s, m);
                chbm_pkg::MODE_SOFT_LIGHT:
                begin
                    k = (m >> 1) + 64;
                    if (s < 128) b = (2 * k * s) / 255;
                    else b = 255 - (2 * (255 - k) * (255 - s) + 254) / 255;
                end
                chbm_pkg::MODE_HARD_LIGHT: return mixw(a, s, ovl(m, s));
                chbm_pkg::MODE_DODGE:      b = dodge(s, m);
                chbm_pkg::MODE_BURN:       b = burn(s, m);
                chbm_pkg::MODE_LIN_LIGHT:
                    return mixw(a, mm, m < 128 ? subc(s, mm) : addc(s, mm));
                chbm_pkg::MODE_VIVID:      return vivid(s, m, a);
                chbm_pkg::MODE_PIN_LIGHT:
                begin
                    if (m < 128) b = s < mm ? s : mm;
                    else b = s > mm ? s : mm;
                    return mixw(a, mm, b);
                end
                chbm_pkg::MODE_HARD_MIX:   return vivid(s, m, a) < 128 ? 0 : 255;
                chbm_pkg::MODE_REFLECT:    b = refl(s, m);
                chbm_pkg::MODE_GLOW:       return mixw(a, s, refl(m, s));
                chbm_pkg::MODE_PHOENIX:    b = (s < m ? s : m) + 255 - (s > m ? s : m);
                chbm_pkg::MODE_DIVIDE:
                begin
                    if (m == 0) b = 255;
                    else
                    begin
                        b = (s * 255) / m;
                        if (b > 255) b = 255;
                    end
                end
                default:         return s;
            endcase
            return mixw(a, m, b);
        endfunction

        function void note_pixel(logic [55:0] px);
            logic [31:0] r;
            int          a;
            int          c;
            a = alpha > 256 ? 256 : int'(alpha);
            r[7:0] = px[7:0];
            for (c = 0; c < 3; c++)
                r[8 * (c + 1) +: 8] = 8'(blend_channel(int'(px[8 * (c + 1) +: 8]),
                                                       int'(px[8 * (c + 4) +: 8]), a));
            pending = {pending, r};
        endfunction

        function void check_pixel(logic [31:0] got);
            logic [31:0] exp_px;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected output beat %h", $time, got);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            for (int f = 0; f < 4; f++)
                if (exp_px[8 * f +: 8] !== got[8 * f +: 8])
                begin
                    $display("%0t: field %0d (mode %0d alpha %0d) expected %0d got %0d",
                             $time, f, mode, alpha, exp_px[8 * f +: 8], got[8 * f +: 8]);
                    errors++;
                end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // src a, r, g, b, mask r, g, b
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // out a, r, g, b
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    blend_scoreboard sb;
    bit              bursty;

    channel_blend_mode_unit_core dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int gap_len();
        if (!bursty) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_pixel(s_axis_tdata);
    end

    // sink stall pattern
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            n = gap_len();
            if (n == 0) m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input chbm_pkg::reg_idx_t idx, input logic [8:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == chbm_pkg::REG_BLEND_MODE) sb.mode = val[4:0];
        else sb.alpha = val;
    endtask

    task automatic send_pixel(input logic [55:0] px);
        int n;
        n = gap_len();
        if (n != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (chbm_pkg::NUM_STAGES + 2) @(posedge clk);
    endtask

    function automatic logic [55:0] rand_pixel();
        logic [55:0] p;
        p = 56'({$urandom, $urandom});
        // bias channels toward extremes and the 128 split now and then
        for (int c = 1; c < 7; c++)
            case ($urandom_range(0, 7))
                0: p[8 * c +: 8] = 8'd0;
                1: p[8 * c +: 8] = 8'd255;
                2: p[8 * c +: 8] = 8'($urandom_range(126, 129));
                default: ;
            endcase
        return p;
    endfunction

    initial
    begin
        logic [8:0] alpha_set[6];
        alpha_set = '{9'd0, 9'd256, 9'd511, 9'd257, 9'd128, 9'd1};
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = chbm_pkg::REG_BLEND_MODE;
        cfg_data = '0;
        bursty = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners on the reset setting, then every mode code, zero alpha on even codes and full on odd
        send_pixel({8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'hA5});
        send_pixel({8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'h5A});
        drain();
        for (int md = 0; md < 32; md++)
        begin
            write_reg(chbm_pkg::REG_BLEND_MODE, 9'(md));
            write_reg(chbm_pkg::REG_MASK_ALPHA, md[0] ? 9'd256 : 9'd0);
            send_pixel({8'd255, 8'd127, 8'd128, 8'd0, 8'd255, 8'd128, 8'h0F});
            send_pixel({8'd0, 8'd128, 8'd127, 8'd255, 8'd0, 8'd127, 8'hF0});
            send_pixel(rand_pixel());
            drain();
        end

        bursty = 1'b1;
        for (int ph = 0; ph < 30; ph++)
        begin
            write_reg(chbm_pkg::REG_BLEND_MODE,
                      ph < 26 ? 9'(ph) : 9'($urandom_range(0, 31)));
            write_reg(chbm_pkg::REG_MASK_ALPHA, $urandom_range(0, 3) == 0
                      ? alpha_set[$urandom_range(0, 5)] : 9'($urandom_range(0, 511)));
            if (ph % 7 == 3) bursty = 1'b0;
            for (int i = 0; i < 12; i++) send_pixel(rand_pixel());
            drain();
            bursty = 1'b1;
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- channel_blend_mode_unit_core.f -----
rtl/core/chbm_pkg.sv
rtl/core/channel_blend_mode_unit_core.sv
sim/tb_channel_blend_mode_unit_core.sv
